### rtl/core/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants of the RGB to HSL converter
// Item structs, divider lane layout and the one-bit restoring division step.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int FULL_SCALE   = (1 << CHANNEL_BITS) - 1;
  localparam int OUT_BITS     = 13;
  localparam int QUO_BITS     = 13;
  localparam int REM_BITS     = CHANNEL_BITS + 14;
  localparam int DVS_BITS     = CHANNEL_BITS + 1;
  localparam int HUE_CIRCLE   = 5760;
  localparam int HUE_SIXTH    = 960;
  localparam int Q12_ONE      = 4096;

  // Lightness divides by the constant 2*FULL_SCALE: halve, then multiply by
  // ceil(2^LIGHT_SHIFT / FULL_SCALE); exact for every dividend in range.
  localparam int     LIGHT_SHIFT = 2 * CHANNEL_BITS + 12;
  localparam longint LIGHT_RECIP =
    ((64'd1 << LIGHT_SHIFT) + FULL_SCALE - 1) / FULL_SCALE;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rhc_in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] hue;
    logic [OUT_BITS-1:0] saturation;
    logic [OUT_BITS-1:0] lightness;
  } rhc_out_t;

  typedef struct packed {
    logic [REM_BITS-1:0] rem;
    logic [DVS_BITS-1:0] dvs;
    logic [QUO_BITS-1:0] quo;
  } rhc_lane_t;

  typedef struct packed {
    rhc_lane_t hue;
    rhc_lane_t sat;
    rhc_lane_t light;
  } rhc_stage_t;

  // One restoring step: try the divisor shifted to quotient bit pos.
  function automatic rhc_lane_t div_step(input rhc_lane_t lane, input int pos);
    rhc_lane_t res;
    logic [REM_BITS-1:0] trial;
    res   = lane;
    trial = REM_BITS'(lane.dvs) << pos;
    if (lane.rem >= trial) begin
      res.rem = lane.rem - trial;
      res.quo = lane.quo | (QUO_BITS'(1) << pos);
    end
    return res;
  endfunction

endpackage

### rtl/core/rhc_prep.sv
// ----------------------------------------------------------------------------
// rhc_prep: front cell of the converter
// Finds max/min, builds dividend and divisor of hue and saturation, lightness.
// ----------------------------------------------------------------------------
module rhc_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  rhc_pkg::rhc_in_t    item_in,
  output logic                vld_out,
  output rhc_pkg::rhc_stage_t stage_out
);

  localparam int CB = rhc_pkg::CHANNEL_BITS;
  localparam int RW = rhc_pkg::REM_BITS;
  localparam int DV = rhc_pkg::DVS_BITS;
  localparam int SW = rhc_pkg::REM_BITS + 1;
  localparam int PW = 2 * CB + 25;

  logic [CB-1:0] r, g, b, mx, mn, d;
  logic [CB:0]   sum, den;
  logic signed [SW-1:0] rs, gs, bs, ds, num, hnum;
  logic [CB+12:0] lnum;
  logic [PW-1:0]  lprod;
  rhc_pkg::rhc_stage_t stage_nxt, stage_r;
  logic vld_r;

  always_comb begin
    r  = item_in.red;
    g  = item_in.green;
    b  = item_in.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d   = mx - mn;
    sum = (CB+1)'(mx) + (CB+1)'(mn);
    den = (sum > (CB+1)'(rhc_pkg::FULL_SCALE)) ?
          (CB+1)'(2 * rhc_pkg::FULL_SCALE) - sum : sum;

    rs = $signed(SW'(r));
    gs = $signed(SW'(g));
    bs = $signed(SW'(b));
    ds = $signed(SW'(d));
    // red wins ties over green, green over blue
    if (r == mx) begin
      num = (gs - bs) * $signed(SW'(rhc_pkg::HUE_SIXTH));
    end else if (g == mx) begin
      num = ds * $signed(SW'(2 * rhc_pkg::HUE_SIXTH))
          + (bs - rs) * $signed(SW'(rhc_pkg::HUE_SIXTH));
    end else begin
      num = ds * $signed(SW'(4 * rhc_pkg::HUE_SIXTH))
          + (rs - gs) * $signed(SW'(rhc_pkg::HUE_SIXTH));
    end
    if (num < 0) begin
      num = num + ds * $signed(SW'(rhc_pkg::HUE_CIRCLE));
    end
    hnum = (num <<< 1) + ds;

    // lightness by reciprocal multiplication, carried through the chain
    lnum  = ((CB+13)'(sum) << 12) + (CB+13)'(rhc_pkg::FULL_SCALE);
    lprod = PW'(lnum[CB+12:1]) * PW'(rhc_pkg::LIGHT_RECIP);

    stage_nxt.hue.quo   = '0;
    stage_nxt.sat.quo   = '0;
    if (d == '0) begin
      // grey: force a zero quotient
      stage_nxt.hue.rem = '0;
      stage_nxt.hue.dvs = DV'(1);
      stage_nxt.sat.rem = '0;
      stage_nxt.sat.dvs = DV'(1);
    end else begin
      stage_nxt.hue.rem = hnum[RW-1:0];
      stage_nxt.hue.dvs = DV'({d, 1'b0});
      stage_nxt.sat.rem = (RW'(d) << 13) + RW'(den);
      stage_nxt.sat.dvs = DV'({den, 1'b0});
    end
    // zero remainder keeps the quotient unchanged in every cell
    stage_nxt.light.quo = lprod[rhc_pkg::LIGHT_SHIFT +: rhc_pkg::QUO_BITS];
    stage_nxt.light.rem = '0;
    stage_nxt.light.dvs = DV'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign vld_out   = vld_r;
  assign stage_out = stage_r;

endmodule

### rtl/core/rhc_div_cell.sv
// ----------------------------------------------------------------------------
// rhc_div_cell: one cell of the division chain
// Resolves one quotient bit in each of the three lanes and passes them on.
// ----------------------------------------------------------------------------
module rhc_div_cell #(
  parameter int BIT_POS = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  rhc_pkg::rhc_stage_t stage_in,
  output logic                vld_out,
  output rhc_pkg::rhc_stage_t stage_out
);

  rhc_pkg::rhc_stage_t stage_nxt, stage_r;
  logic vld_r;

  always_comb begin
    stage_nxt.hue   = rhc_pkg::div_step(stage_in.hue, BIT_POS);
    stage_nxt.sat   = rhc_pkg::div_step(stage_in.sat, BIT_POS);
    stage_nxt.light = rhc_pkg::div_step(stage_in.light, BIT_POS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign vld_out   = vld_r;
  assign stage_out = stage_r;

endmodule

### rtl/core/rgb_to_hsl_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_unit: pixel-stream RGB to HSL converter
// Front cell plus a chain of restoring-division cells, one pixel per clock when not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_item carry one RGB pixel per item; out_valid/out_item carry
//   hue (1/16 degree), saturation and lightness (Q12).
//   An item is taken on an edge with valid high and stall low.
//   Pipeline: one front cell, then 13 division cells, one quotient bit
//   each; the last cell is the output register.
//   Throughput: one item per cycle when not stalled (fully pipelined chain).
//   When out_stall holds off a waiting result, the whole chain freezes and
//   in_stall rises in the same cycle; it never drops an item.
//   Reset clears all valid bits; no item is in flight afterwards.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rhc_pkg::rhc_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output rhc_pkg::rhc_out_t out_item
);

  localparam int QW = rhc_pkg::QUO_BITS;
  localparam int NC = rhc_pkg::QUO_BITS;

  logic                en;
  logic                vld   [NC+1];
  rhc_pkg::rhc_stage_t stage [NC+1];
  logic [QW-1:0]       hue_q;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  rhc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_in    (in_valid),
    .item_in   (in_item),
    .vld_out   (vld[0]),
    .stage_out (stage[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    rhc_div_cell #(
      .BIT_POS (NC - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .vld_in    (vld[i]),
      .stage_in  (stage[i]),
      .vld_out   (vld[i+1]),
      .stage_out (stage[i+1])
    );
  end

  // wrap a full circle back to zero
  assign hue_q = stage[NC].hue.quo;
  assign out_item.hue = (hue_q == QW'(rhc_pkg::HUE_CIRCLE)) ? '0 : hue_q;
  assign out_item.saturation = stage[NC].sat.quo;
  assign out_item.lightness  = stage[NC].light.quo;
  assign out_valid = vld[NC];

`ifndef SYNTHESIS
  a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.hue < 13'(rhc_pkg::HUE_CIRCLE))
    else $error("hue out of range");
  a_sl_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.saturation <= 13'(rhc_pkg::Q12_ONE)
                   && out_item.lightness <= 13'(rhc_pkg::Q12_ONE)))
    else $error("saturation or lightness out of range");
  a_grey : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.hue != '0) |-> out_item.saturation != '0)
    else $error("hue set on a grey pixel");
  a_enter : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted item lost at the front cell");
`endif

endmodule
